>>> src/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk outside reset.
`define SHP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds on a rising edge of clk outside reset.
`define SHP_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> src/shp_pkg.sv
package shp_pkg;

  localparam int HASH_W = 32;
  localparam int CHAR_W = 8;
  localparam int CNT_W  = $clog2(HASH_W);

  localparam int unsigned ALPHABET_MULT   = 256;
  localparam int unsigned DEFAULT_MODULUS = 1000003;

  localparam logic [HASH_W-1:0] MULT_K    = HASH_W'(ALPHABET_MULT);
  localparam logic [HASH_W-1:0] DEF_MOD_K = HASH_W'(DEFAULT_MODULUS);

  // Request to the remainder unit.
  typedef struct packed {
    logic              start;
    logic [HASH_W-1:0] dividend;
    logic [HASH_W-1:0] divisor;
  } rem_req_t;

  // Status back from the remainder unit.
  typedef struct packed {
    logic              busy;
    logic              done;
    logic [HASH_W-1:0] remainder;
  } rem_sts_t;

endpackage

>>> src/shp_ifs.sv
interface shp_in_if;
  logic                        valid;
  logic                        ready;
  logic [shp_pkg::CHAR_W-1:0] char_code;
  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface shp_out_if;
  logic                        valid;
  logic                        ready;
  logic [shp_pkg::HASH_W-1:0] hash_result;
  modport source (output valid, output hash_result, input ready);
  modport sink   (input valid, input hash_result, output ready);
endinterface

interface shp_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [shp_pkg::HASH_W-1:0] mod_value;
  modport source (output valid, output mod_value, input ready);
  modport sink   (input valid, input mod_value, output ready);
endinterface

>>> src/shp_rem.sv
`include "assert_macros.svh"

// Restoring remainder unit: one quotient bit per cycle.
module shp_rem (
  input  logic              clk,
  input  logic              rst_n,
  input  shp_pkg::rem_req_t req,
  output shp_pkg::rem_sts_t sts
);

  logic                        busy_r;
  logic                        done_r;
  logic [shp_pkg::CNT_W-1:0]  cnt_r;
  logic [shp_pkg::HASH_W-1:0] dvd_r;
  logic [shp_pkg::HASH_W-1:0] dvs_r;
  logic [shp_pkg::HASH_W-1:0] rem_r;

  logic [shp_pkg::HASH_W:0]   trial;
  logic [shp_pkg::HASH_W:0]   diff;
  logic                        ge;
  logic [shp_pkg::HASH_W-1:0] rem_nxt;

  always_comb begin
    trial   = {rem_r, dvd_r[shp_pkg::HASH_W-1]};
    diff    = trial - {1'b0, dvs_r};
    ge      = (trial >= {1'b0, dvs_r});
    rem_nxt = ge ? diff[shp_pkg::HASH_W-1:0] : trial[shp_pkg::HASH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        dvd_r  <= req.dividend;
        dvs_r  <= req.divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        dvd_r <= {dvd_r[shp_pkg::HASH_W-2:0], 1'b0};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == {shp_pkg::CNT_W{1'b1}}) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign sts.busy      = busy_r;
  assign sts.done      = done_r;
  assign sts.remainder = rem_r;

  `SHP_ASSERT(a_rem_below_mod, done_r |-> (rem_r < dvs_r), "remainder not below divisor")
  `SHP_ASSERT(a_done_single, done_r |=> !done_r, "done held longer than one cycle")

endmodule

>>> src/string_polynomial_hash_mod_top.sv
// Polynomial rolling string hash with a programmable modulus.
// in_ch carries one string byte per word (char_code). A nonzero byte folds
// into the running hash as ((hash * 256 + byte) mod 2^32) mod M, where M is
// the modulus register, or 1000003 when that register is zero. A zero byte
// ends the string: the running hash goes out on out_ch as one word and
// clears to 0.
// cfg_ch writes the modulus register; it is always ready and should be
// written only while the block is idle.
// A nonzero byte is accepted, run through 32 steps of the bit-serial
// remainder unit, then written back; in_ch.ready is low meanwhile.
// A zero byte needs no division; its hash is valid on out_ch the next cycle.
// The result sits in an output register; a stalled receiver holds it there,
// and beyond the busy cycles in_ch.ready also stays low while that register
// is full and not taken.
// Reset (rst_n low, synchronous) clears the hash, the modulus register, the
// sequencer and the output valid.
module string_polynomial_hash_mod_top (
  input  logic      clk,
  input  logic      rst_n,
  shp_in_if.sink    in_ch,
  shp_out_if.source out_ch,
  shp_cfg_if.sink   cfg_ch
);

  typedef enum logic {
    ST_IDLE,
    ST_WAIT
  } state_t;

  state_t                      state_r;
  logic [shp_pkg::HASH_W-1:0] hash_r;
  logic [shp_pkg::HASH_W-1:0] tsize_r;
  logic                        out_valid_r;
  logic [shp_pkg::HASH_W-1:0] out_hash_r;

  logic                        in_acc;
  logic                        is_term;
  logic [shp_pkg::HASH_W-1:0] sum;
  logic [shp_pkg::HASH_W-1:0] modulus;
  shp_pkg::rem_req_t           rem_req;
  shp_pkg::rem_sts_t           rem_sts;

  // Accept a byte only when idle and the output register can take a word.
  assign in_ch.ready = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign is_term     = (in_ch.char_code == '0);

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    // Wrap to 32 bits before reduction.
    sum = hash_r * shp_pkg::MULT_K
          + {{(shp_pkg::HASH_W-shp_pkg::CHAR_W){1'b0}}, in_ch.char_code};
    modulus = (tsize_r == '0) ? shp_pkg::DEF_MOD_K : tsize_r;
    rem_req.start    = in_acc && !is_term;
    rem_req.dividend = sum;
    rem_req.divisor  = modulus;
  end

  shp_rem u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rem_req),
    .sts   (rem_sts)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      hash_r      <= '0;
      tsize_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        tsize_r <= cfg_ch.mod_value;
      end
      // Drop the output word once taken, unless a terminator refills it now.
      if (out_ch.ready && !(in_acc && is_term)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (is_term) begin
              out_valid_r <= 1'b1;
              out_hash_r  <= hash_r;
              hash_r      <= '0;
            end else begin
              state_r <= ST_WAIT;
            end
          end
        end
        ST_WAIT: begin
          // Hold until the remainder unit finishes, then write back.
          if (rem_sts.done) begin
            hash_r  <= rem_sts.remainder;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.hash_result = out_hash_r;

  `SHP_NEVER(a_ready_while_busy, in_ch.ready && rem_sts.busy, "input ready while unit busy")
  `SHP_ASSERT(a_term_clears, (in_acc && is_term) |=> (hash_r == '0), "hash not cleared")
  `SHP_NEVER(a_done_outside_wait, rem_sts.done && (state_r != ST_WAIT), "unexpected done")

endmodule

>>> bench/tb_string_polynomial_hash_mod_top.sv
`timescale 1ns / 1ps

module tb_string_polynomial_hash_mod_top;

  localparam int HASH_W = shp_pkg::HASH_W;
  localparam int CHAR_W = shp_pkg::CHAR_W;

  // Longest run of cycles with no word moving on any channel. The slowest
  // correct stretch is the receiver hold-off below plus a few byte times.
  localparam int STALL_LIMIT   = 2000;
  // Time for a nonzero byte still in the block to finish, with some margin,
  // before touching the modulus register or ending the run.
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int MAX_REPORTS   = 10;

  logic clk;
  logic rst_n;

  shp_in_if  in_ch ();
  shp_out_if out_ch ();
  shp_cfg_if cfg_ch ();

  string_polynomial_hash_mod_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Mirror of the block: running hash and the modulus register last written.
  logic [HASH_W-1:0] model_hash;
  logic [HASH_W-1:0] model_modulus;
  // Hashes of terminated strings, oldest first, waiting on out_ch.
  logic [HASH_W-1:0] pending_hashes[$];
  logic [HASH_W-1:0] want_hash;

  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int hold_left      = 0;
  int mismatch_count = 0;
  int stall_cycles   = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // One polynomial step: multiply and add wrap at 32 bits, then reduce by
  // the modulus register, or by the default prime when it is zero.
  function automatic logic [HASH_W-1:0] fold_char(input logic [HASH_W-1:0] acc,
                                                  input logic [CHAR_W-1:0] c,
                                                  input logic [HASH_W-1:0] tsize);
    logic [HASH_W-1:0] sum;
    logic [HASH_W-1:0] modulus;
    sum     = acc * shp_pkg::MULT_K + {{(HASH_W-CHAR_W){1'b0}}, c};
    modulus = (tsize == '0) ? shp_pkg::DEF_MOD_K : tsize;
    return sum % modulus;
  endfunction

  task automatic report_mismatch(input string what, input logic [HASH_W-1:0] want,
                                 input logic [HASH_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t: %s: expected hash_result 0x%08h, got 0x%08h", $time, what, want, got);
  endtask

  // Offer one byte. Called at a falling edge; returns at the falling edge
  // after acceptance with valid still high, so a following byte goes out
  // back to back. Whoever stops sending must drop valid.
  task automatic send_char(input logic [CHAR_W-1:0] c);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_ch.valid     = 1'b0;
      in_ch.char_code = CHAR_W'($urandom);
      @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.char_code = c;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    // Word taken at this edge: advance the mirror.
    if (c == '0) begin
      pending_hashes.push_back(model_hash);
      model_hash = '0;
    end else begin
      model_hash = fold_char(model_hash, c, model_modulus);
    end
    @(negedge clk);
  endtask

  // Drop valid, wait for every outstanding hash, then let a byte that is
  // still in the remainder unit finish.
  task automatic wait_idle();
    in_ch.valid = 1'b0;
    while (pending_hashes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write the modulus register, only once the block has gone quiet.
  task automatic set_modulus(input logic [HASH_W-1:0] tsize);
    wait_idle();
    cfg_ch.valid     = 1'b1;
    cfg_ch.mod_value = tsize;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    model_modulus = tsize;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // A terminator with nothing before it must give zero.
  task automatic test_empty_string();
    send_char('0);
    wait_idle();
  endtask

  // Smallest, middle and largest byte under the default modulus.
  task automatic test_byte_extremes();
    send_char(8'h01);
    send_char(8'h80);
    send_char(8'hFF);
    send_char('0);
    wait_idle();
  endtask

  // With the widest modulus the hash climbs past 2^24, so hash*256 wraps
  // at 32 bits before the reduction.
  task automatic test_hash_wrap();
    set_modulus('1);
    send_char(8'hFF);
    send_char(8'hFF);
    send_char(8'hFF);
    send_char(8'hFE);
    send_char(8'hFF);
    send_char(8'h80);
    send_char('0);
    wait_idle();
  endtask

  // Change the modulus in the middle of a string: the held hash is not
  // reduced again, so the terminator emits a value above the new modulus.
  task automatic test_modulus_change_midstring();
    set_modulus('0);
    send_char(8'h61);
    send_char(8'h62);
    send_char(8'h63);
    set_modulus(32'd7);
    send_char('0);
    // Modulus of one folds every byte to zero.
    set_modulus(32'd1);
    send_char(8'h05);
    send_char('0);
    wait_idle();
  endtask

  // Hold the receiver off for a long stretch while bytes keep coming: the
  // output register fills and the block must stall in_ch until released.
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left     = HOLD_CYCLES;
    send_char(8'h41);
    send_char('0);
    send_char('0);
    send_char(8'h42);
    send_char(8'h43);
    send_char('0);
    send_char('0);
    wait_idle();
  endtask

  // Random strings in segments, each under its own modulus. The first
  // segments walk the extreme moduli. A segment may end mid-string, so the
  // next modulus takes over a partly built hash. One string in ten is noise
  // that may carry zero bytes anywhere.
  task automatic test_random_strings(input int s_pct, input int r_pct, input int n_items);
    int                sent;
    int                seg;
    int                seg_len;
    int                str_left;
    bit                noisy;
    logic [HASH_W-1:0] tsize;
    sent          = 0;
    seg           = 0;
    str_left      = 0;
    noisy         = 1'b0;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    while (sent < n_items) begin
      case (seg)
        0: tsize = '0;
        1: tsize = 32'd1;
        2: tsize = '1;
        3: tsize = 32'h8000_0000;
        default: begin
          case ($urandom_range(3, 0))
            0: tsize = '0;
            1: tsize = 32'd2;
            2: tsize = $urandom_range(1000, 3);
            default: tsize = $urandom;
          endcase
        end
      endcase
      set_modulus(tsize);
      seg++;
      seg_len = $urandom_range(80, 30);
      repeat (seg_len) begin
        if (str_left == 0) begin
          send_char('0);
          noisy    = ($urandom_range(9, 0) == 0);
          str_left = ($urandom_range(7, 0) == 0) ? $urandom_range(40, 9)
                                                 : $urandom_range(8, 0);
        end else begin
          send_char(noisy ? CHAR_W'($urandom) : CHAR_W'($urandom_range(255, 1)));
          str_left--;
        end
        sent++;
        // Now and then pause the sender until every hash is back.
        if ($urandom_range(49, 0) == 0) wait_idle();
      end
    end
    wait_idle();
  endtask

  // Receiver: honor a pending hold-off first, else stall at random.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else begin
        out_ch.ready = ($urandom_range(99, 0) >= recv_idle_pct);
      end
    end
  end

  // Compare every accepted result word with the oldest pending hash.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_hashes.size() == 0) begin
        report_mismatch("unexpected word", 'x, out_ch.hash_result);
      end else begin
        want_hash = pending_hashes.pop_front();
        if (out_ch.hash_result !== want_hash)
          report_mismatch("hash mismatch", want_hash, out_ch.hash_result);
      end
    end
  end

  // Watchdog: end the run when no word moves for too long.
  initial begin
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst_n !== 1'b1 || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("[string_polynomial_hash_mod_top] ERROR");
    $finish;
  end

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.char_code  = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.mod_value = '0;
    model_hash       = '0;
    model_modulus    = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_empty_string();
    test_byte_extremes();
    test_hash_wrap();
    test_modulus_change_midstring();
    test_output_backpressure();
    test_random_strings(34, 63, 260);
    test_random_strings(63, 34, 260);
    test_random_strings(0, 0, 260);

    if (mismatch_count == 0)
      $display("[string_polynomial_hash_mod_top] OK");
    else
      $display("[string_polynomial_hash_mod_top] ERROR");
    $finish;
  end

endmodule
